// ===== rtl/core/owmm_pkg.sv =====
// Shared types, widths and constants of the omni-wheel motion mixer.
package owmm_pkg;

  // Field widths
  localparam int STICK_W = 11;
  localparam int KEYS_W  = 16;
  localparam int MOUSE_W = 16;
  localparam int SCALE_W = 10;
  localparam int WHEEL_W = 22;

  // Internal widths, sized to the value ranges
  localparam int XY_W    = 13;               // signed strafe/forward demand
  localparam int Z_W     = 21;               // signed rotate demand
  localparam int AXY_W   = 11;               // |strafe|, |forward| <= 1684
  localparam int AZ_W    = 20;               // |rotate| <= 984064
  localparam int TOT_W   = 20;               // sum of magnitudes <= 987432
  localparam int PROD_W  = AZ_W + SCALE_W;   // biggest * scale
  localparam int TOP_W   = 21;               // top speed <= 1525299
  localparam int NUM_W   = TOP_W + TOT_W;    // divider numerator
  localparam int LANES   = 3;
  localparam int SUM_W   = WHEEL_W + 1;

  // Arithmetic constants
  localparam int STICK_CENTRE = 1024;
  localparam int KEY_STEP     = 660;
  localparam int MOUSE_GAIN   = 30;

  // Reciprocal of 660: floor(p * RECIP_M >> RECIP_SHIFT) == p / 660 for p < 2**30
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 40;
  localparam logic [RECIP_W-1:0] RECIP_M = 31'd1665926709;

  // Divider lanes
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // Key bit positions
  localparam int KEY_W     = 0;
  localparam int KEY_S     = 1;
  localparam int KEY_A     = 2;
  localparam int KEY_D     = 3;
  localparam int KEY_BOOST = 4;
  localparam int KEY_CRAWL = 5;

  // Mode switch positions
  localparam logic [1:0] SW_HIGH = 2'd1;
  localparam logic [1:0] SW_LOW  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd2;

  // Configuration reset values
  localparam logic [SCALE_W-1:0] HIGH_RST   = 10'd180;
  localparam logic [SCALE_W-1:0] NORMAL_RST = 10'd110;
  localparam logic [SCALE_W-1:0] LOW_RST    = 10'd60;

  // Sideband that travels with a request through the divider
  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } side_t;

endpackage

// ===== rtl/core/owmm_div_pipe.sv =====
// Pipelined multi-lane restoring divider, one quotient bit per stage.
module owmm_div_pipe #(
  parameter int QUOT_W = owmm_pkg::TOP_W,
  parameter int DEN_W  = owmm_pkg::TOT_W,
  parameter int LANES  = owmm_pkg::LANES,
  localparam int NUM_W = QUOT_W + DEN_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  owmm_pkg::side_t                    in_side,
  input  logic [DEN_W-1:0]                   in_den,
  input  logic [LANES-1:0][NUM_W-1:0]        in_num,
  output logic                               out_valid,
  output owmm_pkg::side_t                    out_side,
  output logic [LANES-1:0][QUOT_W-1:0]       out_quot
);

  logic [QUOT_W-1:0]                  valid_r;
  owmm_pkg::side_t                    side_r [QUOT_W];
  logic [DEN_W-1:0]                   den_r  [QUOT_W-1];
  logic [LANES-1:0][NUM_W-1:0]        rem_r  [QUOT_W-1];
  logic [LANES-1:0][QUOT_W-1:0]       quot_r [QUOT_W];

  logic [DEN_W-1:0]                   den_in   [QUOT_W];
  logic [LANES-1:0][NUM_W-1:0]        rem_in   [QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0]       quot_in  [QUOT_W];
  logic [LANES-1:0][NUM_W-1:0]        rem_nxt  [QUOT_W-1];
  logic [LANES-1:0][QUOT_W-1:0]       quot_nxt [QUOT_W];

  // Trial subtract of the shifted divisor in every stage and lane
  always_comb begin
    logic [NUM_W-1:0] den_sh;
    logic             take;
    rem_in[0]  = in_num;
    quot_in[0] = '0;
    den_in[0]  = in_den;
    for (int k = 1; k < QUOT_W; k++) begin
      rem_in[k]  = rem_r[k-1];
      quot_in[k] = quot_r[k-1];
      den_in[k]  = den_r[k-1];
    end
    for (int k = 0; k < QUOT_W; k++) begin
      den_sh = NUM_W'(den_in[k]) << (QUOT_W - 1 - k);
      for (int l = 0; l < LANES; l++) begin
        take = (rem_in[k][l] >= den_sh);
        quot_nxt[k][l] = quot_in[k][l] | (QUOT_W'(take) << (QUOT_W - 1 - k));
        if (k < QUOT_W - 1) begin
          rem_nxt[k][l] = take ? (rem_in[k][l] - den_sh) : rem_in[k][l];
        end
      end
    end
  end

  // Advance valid bits when the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[QUOT_W-2:0], in_valid};
    end
  end

  // Advance payload when the pipeline moves
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < QUOT_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int k = 0; k < QUOT_W - 1; k++) begin
        den_r[k] <= den_in[k];
        rem_r[k] <= rem_nxt[k];
      end
      for (int k = 0; k < QUOT_W; k++) begin
        quot_r[k] <= quot_nxt[k];
      end
    end
  end

  assign out_valid = valid_r[QUOT_W-1];
  assign out_side  = side_r[QUOT_W-1];
  assign out_quot  = quot_r[QUOT_W-1];

endmodule

// ===== rtl/core/omni_wheel_motion_mixer.sv =====
// Top level of the omni-wheel motion mixer: mixes a control frame into four wheel speeds.
// Pipeline: 5 front stages, 21 pipelined proportional divider stages and one output
//   register lie between request acceptance and result valid.
// Throughput: one request per cycle while the output is not stalled; the divider sets depth.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the speed scales 180/110/60.
module omni_wheel_motion_mixer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [owmm_pkg::STICK_W-1:0]           in_stick_strafe,
  input  logic [owmm_pkg::STICK_W-1:0]           in_stick_forward,
  input  logic [owmm_pkg::STICK_W-1:0]           in_stick_rotate,
  input  logic [1:0]                             in_mode_switch,
  input  logic [owmm_pkg::KEYS_W-1:0]            in_key_mask,
  input  logic signed [owmm_pkg::MOUSE_W-1:0]    in_mouse_dx,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [owmm_pkg::WHEEL_W-1:0]    out_wheel_one,
  output logic signed [owmm_pkg::WHEEL_W-1:0]    out_wheel_two,
  output logic signed [owmm_pkg::WHEEL_W-1:0]    out_wheel_three,
  output logic signed [owmm_pkg::WHEEL_W-1:0]    out_wheel_four,
  // Configuration port
  input  logic                                   cfg_we,
  input  logic [owmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [owmm_pkg::SCALE_W-1:0]           cfg_data
);

  localparam int XY_W    = owmm_pkg::XY_W;
  localparam int Z_W     = owmm_pkg::Z_W;
  localparam int AXY_W   = owmm_pkg::AXY_W;
  localparam int AZ_W    = owmm_pkg::AZ_W;
  localparam int TOT_W   = owmm_pkg::TOT_W;
  localparam int SCALE_W = owmm_pkg::SCALE_W;
  localparam int PROD_W  = owmm_pkg::PROD_W;
  localparam int TOP_W   = owmm_pkg::TOP_W;
  localparam int NUM_W   = owmm_pkg::NUM_W;
  localparam int LANES   = owmm_pkg::LANES;
  localparam int SUM_W   = owmm_pkg::SUM_W;
  localparam int WHEEL_W = owmm_pkg::WHEEL_W;

  logic adv;
  logic out_valid_r;

  // Move the whole pipeline unless a result is waiting
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------- config
  logic [SCALE_W-1:0] high_r, normal_r, low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r   <= owmm_pkg::HIGH_RST;
      normal_r <= owmm_pkg::NORMAL_RST;
      low_r    <= owmm_pkg::LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        owmm_pkg::CFG_HIGH:   high_r   <= cfg_data;
        owmm_pkg::CFG_NORMAL: normal_r <= cfg_data;
        owmm_pkg::CFG_LOW:    low_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic signed [XY_W-1:0] x0, y0;
  logic signed [Z_W-1:0]  z0;
  logic [AXY_W-1:0]       ax0, ay0;
  logic [AZ_W-1:0]        az0;
  logic [SCALE_W-1:0]     scale0;

  // Decode keys, form demands and their magnitudes
  always_comb begin
    x0 = $signed({2'b00, in_stick_strafe}) - XY_W'(owmm_pkg::STICK_CENTRE)
       + (in_key_mask[owmm_pkg::KEY_D] ? XY_W'(owmm_pkg::KEY_STEP) : XY_W'(0))
       - (in_key_mask[owmm_pkg::KEY_A] ? XY_W'(owmm_pkg::KEY_STEP) : XY_W'(0));
    y0 = $signed({2'b00, in_stick_forward}) - XY_W'(owmm_pkg::STICK_CENTRE)
       + (in_key_mask[owmm_pkg::KEY_W] ? XY_W'(owmm_pkg::KEY_STEP) : XY_W'(0))
       - (in_key_mask[owmm_pkg::KEY_S] ? XY_W'(owmm_pkg::KEY_STEP) : XY_W'(0));
    z0 = $signed({10'b0, in_stick_rotate}) - Z_W'(owmm_pkg::STICK_CENTRE)
       + Z_W'(in_mouse_dx) * Z_W'(owmm_pkg::MOUSE_GAIN);
    ax0 = AXY_W'(x0[XY_W-1] ? -x0 : x0);
    ay0 = AXY_W'(y0[XY_W-1] ? -y0 : y0);
    az0 = AZ_W'(z0[Z_W-1] ? -z0 : z0);
  end

  // Pick the speed scale: Shift over Ctrl over the switch
  always_comb begin
    case (in_mode_switch)
      owmm_pkg::SW_HIGH: scale0 = high_r;
      owmm_pkg::SW_LOW:  scale0 = low_r;
      default:           scale0 = normal_r;
    endcase
    if (in_key_mask[owmm_pkg::KEY_CRAWL]) begin
      scale0 = low_r;
    end
    if (in_key_mask[owmm_pkg::KEY_BOOST]) begin
      scale0 = high_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic               v1_r;
  logic [AXY_W-1:0]   ax1_r, ay1_r;
  logic [AZ_W-1:0]    az1_r;
  logic [2:0]         neg1_r;
  logic [SCALE_W-1:0] scale1_r;
  logic [AZ_W-1:0]    big1;
  logic [TOT_W-1:0]   tot1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r    <= ax0;
      ay1_r    <= ay0;
      az1_r    <= az0;
      neg1_r   <= {x0[XY_W-1], y0[XY_W-1], z0[Z_W-1]};
      scale1_r <= scale0;
    end
  end

  // Largest magnitude and sum of magnitudes
  always_comb begin
    big1 = az1_r;
    if (AZ_W'(ax1_r) > big1) begin
      big1 = AZ_W'(ax1_r);
    end
    if (AZ_W'(ay1_r) > big1) begin
      big1 = AZ_W'(ay1_r);
    end
    tot1 = TOT_W'(ax1_r) + TOT_W'(ay1_r) + TOT_W'(az1_r);
  end

  // ---------------------------------------------------------------- stage 2
  logic               v2_r;
  logic [AXY_W-1:0]   ax2_r, ay2_r;
  logic [AZ_W-1:0]    az2_r;
  logic [2:0]         neg2_r;
  logic [SCALE_W-1:0] scale2_r;
  logic [AZ_W-1:0]    big2_r;
  logic [TOT_W-1:0]   tot2_r;
  logic [PROD_W-1:0]  prod2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax2_r    <= ax1_r;
      ay2_r    <= ay1_r;
      az2_r    <= az1_r;
      neg2_r   <= neg1_r;
      scale2_r <= scale1_r;
      big2_r   <= big1;
      tot2_r   <= tot1;
    end
  end

  // Scaled top speed before the divide by 660
  assign prod2 = big2_r * scale2_r;

  // ---------------------------------------------------------------- stage 3
  logic                      v3_r;
  logic [AXY_W-1:0]          ax3_r, ay3_r;
  logic [AZ_W-1:0]           az3_r;
  logic [2:0]                neg3_r;
  logic [TOT_W-1:0]          tot3_r;
  logic [PROD_W-1:0]         prod3_r;
  logic [PROD_W+owmm_pkg::RECIP_W-1:0] recip3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      az3_r   <= az2_r;
      neg3_r  <= neg2_r;
      tot3_r  <= tot2_r;
      prod3_r <= prod2;
    end
  end

  // Divide by 660 through the reciprocal
  assign recip3 = prod3_r * owmm_pkg::RECIP_M;

  // ---------------------------------------------------------------- stage 4
  logic              v4_r;
  logic [AXY_W-1:0]  ax4_r, ay4_r;
  logic [AZ_W-1:0]   az4_r;
  logic [2:0]        neg4_r;
  logic [TOT_W-1:0]  tot4_r;
  logic [TOP_W-1:0]  top4_r;
  logic [AXY_W+TOP_W-1:0] px4, py4;
  logic [AZ_W+TOP_W-1:0]  pz4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;
      az4_r  <= az3_r;
      neg4_r <= neg3_r;
      tot4_r <= tot3_r;
      top4_r <= recip3[owmm_pkg::RECIP_SHIFT +: TOP_W];
    end
  end

  // Demand magnitude times top speed, per lane
  assign px4 = ax4_r * top4_r;
  assign py4 = ay4_r * top4_r;
  assign pz4 = az4_r * top4_r;

  // ---------------------------------------------------------------- stage 5
  logic                        v5_r;
  logic [LANES-1:0][NUM_W-1:0] num5_r;
  logic [TOT_W-1:0]            tot5_r;
  owmm_pkg::side_t             side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num5_r[owmm_pkg::LANE_X] <= NUM_W'(px4);
      num5_r[owmm_pkg::LANE_Y] <= NUM_W'(py4);
      num5_r[owmm_pkg::LANE_Z] <= NUM_W'(pz4);
      tot5_r        <= tot4_r;
      side5_r.zero  <= (tot4_r == '0);
      side5_r.neg_x <= neg4_r[2];
      side5_r.neg_y <= neg4_r[1];
      side5_r.neg_z <= neg4_r[0];
    end
  end

  // ---------------------------------------------------------------- divider
  logic                        dv_valid;
  owmm_pkg::side_t             dv_side;
  logic [LANES-1:0][TOP_W-1:0] dv_quot;

  owmm_div_pipe #(
    .QUOT_W (TOP_W),
    .DEN_W  (TOT_W),
    .LANES  (LANES)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v5_r),
    .in_side   (side5_r),
    .in_den    (tot5_r),
    .in_num    (num5_r),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quot  (dv_quot)
  );

  // ---------------------------------------------------------------- output
  logic signed [SUM_W-1:0]   vs, vf, vr;
  logic signed [WHEEL_W-1:0] one_nxt, two_nxt, three_nxt, four_nxt;
  logic signed [WHEEL_W-1:0] one_r, two_r, three_r, four_r;

  // Restore signs and mix into wheel speeds
  always_comb begin
    vs = $signed({2'b00, dv_quot[owmm_pkg::LANE_X]});
    vf = $signed({2'b00, dv_quot[owmm_pkg::LANE_Y]});
    vr = $signed({2'b00, dv_quot[owmm_pkg::LANE_Z]});
    if (dv_side.neg_x) begin
      vs = -vs;
    end
    if (dv_side.neg_y) begin
      vf = -vf;
    end
    if (dv_side.neg_z) begin
      vr = -vr;
    end
    if (dv_side.zero) begin
      vs = '0;
      vf = '0;
      vr = '0;
    end
    one_nxt   = WHEEL_W'(vf + vs + vr);
    two_nxt   = WHEEL_W'(vf - vs - vr);
    three_nxt = WHEEL_W'(vf - vs + vr);
    four_nxt  = WHEEL_W'(vf + vs - vr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      one_r   <= one_nxt;
      two_r   <= two_nxt;
      three_r <= three_nxt;
      four_r  <= four_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wheel_one   = one_r;
  assign out_wheel_two   = two_r;
  assign out_wheel_three = three_r;
  assign out_wheel_four  = four_r;

`ifndef ASSERT_OFF
  // A frame with no demand leaves the output stage as all zeros
  a_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && dv_valid && dv_side.zero) |=>
      (one_r == '0 && two_r == '0 && three_r == '0 && four_r == '0))
    else $error("zero-demand frame produced nonzero wheel speed");

  // The largest magnitude never exceeds the sum of magnitudes
  a_big_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (TOT_W'(big2_r) <= tot2_r))
    else $error("largest demand exceeds sum of demands");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  // The pipeline valid bits stay put while a held result is not taken
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (v5_r == $past(v5_r) && dv_valid == $past(dv_valid)))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== bench/omni_wheel_motion_mixer_tb.sv =====
// Self-checking testbench of the omni-wheel motion mixer: random and directed frames.
module omni_wheel_motion_mixer_tb;

  localparam int STICK_W      = owmm_pkg::STICK_W;
  localparam int KEYS_W       = owmm_pkg::KEYS_W;
  localparam int MOUSE_W      = owmm_pkg::MOUSE_W;
  localparam int WHEEL_W      = owmm_pkg::WHEEL_W;
  localparam int SCALE_W      = owmm_pkg::SCALE_W;
  localparam int CFG_IDX_W    = owmm_pkg::CFG_IDX_W;
  localparam int STICK_CENTRE = owmm_pkg::STICK_CENTRE;
  localparam int KEY_STEP     = owmm_pkg::KEY_STEP;
  localparam int MOUSE_GAIN   = owmm_pkg::MOUSE_GAIN;
  localparam int KEY_W        = owmm_pkg::KEY_W;
  localparam int KEY_S        = owmm_pkg::KEY_S;
  localparam int KEY_A        = owmm_pkg::KEY_A;
  localparam int KEY_D        = owmm_pkg::KEY_D;
  localparam int KEY_BOOST    = owmm_pkg::KEY_BOOST;
  localparam int KEY_CRAWL    = owmm_pkg::KEY_CRAWL;
  localparam logic [1:0] SW_HIGH = owmm_pkg::SW_HIGH;
  localparam logic [1:0] SW_LOW  = owmm_pkg::SW_LOW;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = owmm_pkg::CFG_HIGH;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = owmm_pkg::CFG_NORMAL;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = owmm_pkg::CFG_LOW;
  localparam logic [SCALE_W-1:0] HIGH_RST   = owmm_pkg::HIGH_RST;
  localparam logic [SCALE_W-1:0] NORMAL_RST = owmm_pkg::NORMAL_RST;
  localparam logic [SCALE_W-1:0] LOW_RST    = owmm_pkg::LOW_RST;

  localparam longint TOP_DIV      = 660;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_MARGIN = 40;
  localparam int     PHASE_ITEMS  = 128;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [STICK_W-1:0]        strafe;
    logic [STICK_W-1:0]        forward;
    logic [STICK_W-1:0]        rotate;
    logic [1:0]                mode;
    logic [KEYS_W-1:0]         keys;
    logic signed [MOUSE_W-1:0] mouse;
  } frame_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] one;
    logic signed [WHEEL_W-1:0] two;
    logic signed [WHEEL_W-1:0] three;
    logic signed [WHEEL_W-1:0] four;
  } wheel_set_t;

  // Predict wheel speeds per frame and hold them until the block returns them
  class wheel_scoreboard;
    logic [SCALE_W-1:0] scale_high;
    logic [SCALE_W-1:0] scale_normal;
    logic [SCALE_W-1:0] scale_low;
    wheel_set_t         wheels_q[$];
    int unsigned        mismatches;
    int unsigned        frames_seen;
    int unsigned        results_checked;

    function new();
      scale_high   = HIGH_RST;
      scale_normal = NORMAL_RST;
      scale_low    = LOW_RST;
      mismatches   = 0;
      frames_seen  = 0;
      results_checked = 0;
    endfunction

    function void write_scale(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] val);
      case (idx)
        CFG_HIGH:   scale_high   = val;
        CFG_NORMAL: scale_normal = val;
        CFG_LOW:    scale_low    = val;
        default: ;
      endcase
    endfunction

    function wheel_set_t mix_frame(frame_t f);
      longint x, y, z, ax, ay, az, peak, scale, top, total, vf, vs, vr;
      wheel_set_t w;
      x = longint'(f.strafe) - STICK_CENTRE
          + (longint'(f.keys[KEY_D]) - longint'(f.keys[KEY_A])) * KEY_STEP;
      y = longint'(f.forward) - STICK_CENTRE
          + (longint'(f.keys[KEY_W]) - longint'(f.keys[KEY_S])) * KEY_STEP;
      z = longint'(f.rotate) - STICK_CENTRE + longint'($signed(f.mouse)) * MOUSE_GAIN;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      peak = ax;
      if (ay > peak) peak = ay;
      if (az > peak) peak = az;
      // Switch picks the scale; Ctrl forces low, Shift forces high and wins
      case (f.mode)
        SW_HIGH: scale = scale_high;
        SW_LOW:  scale = scale_low;
        default: scale = scale_normal;
      endcase
      if (f.keys[KEY_CRAWL]) scale = scale_low;
      if (f.keys[KEY_BOOST]) scale = scale_high;
      top   = (peak * scale) / TOP_DIV;
      total = ax + ay + az;
      vf = 0;
      vs = 0;
      vr = 0;
      if (total != 0) begin
        vf = (y * top) / total;
        vs = (x * top) / total;
        vr = (z * top) / total;
      end
      w.one   = WHEEL_W'(vf + vs + vr);
      w.two   = WHEEL_W'(vf - vs - vr);
      w.three = WHEEL_W'(vf - vs + vr);
      w.four  = WHEEL_W'(vf + vs - vr);
      return w;
    endfunction

    function void note_request(frame_t f);
      wheels_q.push_back(mix_frame(f));
      frames_seen++;
    endfunction

    function void check_result(wheel_set_t got);
      wheel_set_t exp_w;
      if (wheels_q.size() == 0) begin
        $display("%0t: result with no request pending: %0d %0d %0d %0d", $time,
                 got.one, got.two, got.three, got.four);
        mismatches++;
        return;
      end
      exp_w = wheels_q.pop_front();
      results_checked++;
      if (got.one !== exp_w.one) begin
        $display("%0t: wheel_one expected %0d actual %0d", $time, exp_w.one, got.one);
        mismatches++;
      end
      if (got.two !== exp_w.two) begin
        $display("%0t: wheel_two expected %0d actual %0d", $time, exp_w.two, got.two);
        mismatches++;
      end
      if (got.three !== exp_w.three) begin
        $display("%0t: wheel_three expected %0d actual %0d", $time, exp_w.three, got.three);
        mismatches++;
      end
      if (got.four !== exp_w.four) begin
        $display("%0t: wheel_four expected %0d actual %0d", $time, exp_w.four, got.four);
        mismatches++;
      end
    endfunction

    function int pending();
      return wheels_q.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [STICK_W-1:0]         in_stick_strafe;
  logic [STICK_W-1:0]         in_stick_forward;
  logic [STICK_W-1:0]         in_stick_rotate;
  logic [1:0]                 in_mode_switch;
  logic [KEYS_W-1:0]          in_key_mask;
  logic signed [MOUSE_W-1:0]  in_mouse_dx;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [WHEEL_W-1:0]  out_wheel_one;
  logic signed [WHEEL_W-1:0]  out_wheel_two;
  logic signed [WHEEL_W-1:0]  out_wheel_three;
  logic signed [WHEEL_W-1:0]  out_wheel_four;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [SCALE_W-1:0]         cfg_data;

  wheel_scoreboard sb;
  int unsigned     cycle_count;
  int unsigned     settings_used;
  bit              hold_off_req;
  int unsigned     ready_pct;

  omni_wheel_motion_mixer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stick_strafe  (in_stick_strafe),
    .in_stick_forward (in_stick_forward),
    .in_stick_rotate  (in_stick_rotate),
    .in_mode_switch   (in_mode_switch),
    .in_key_mask      (in_key_mask),
    .in_mouse_dx      (in_mouse_dx),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_wheel_one    (out_wheel_one),
    .out_wheel_two    (out_wheel_two),
    .out_wheel_three  (out_wheel_three),
    .out_wheel_four   (out_wheel_four),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if it stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // Record each accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request({in_stick_strafe, in_stick_forward, in_stick_rotate,
                       in_mode_switch, in_key_mask, in_mouse_dx});
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_wheel_one, out_wheel_two, out_wheel_three, out_wheel_four});
  end

  // Receiver: stall on its own pattern, hold off for a long stretch on request
  initial begin
    int unsigned tick;
    tick = 0;
    ready_pct = 100;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    ready_pct = 100;
          2:       ready_pct = 70;
          3:       ready_pct = 40;
          default: ready_pct = 15;
        endcase
      end
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  function automatic frame_t make_frame(int s, int f, int r, int m, int k, int d);
    frame_t fr;
    fr.strafe  = STICK_W'(s);
    fr.forward = STICK_W'(f);
    fr.rotate  = STICK_W'(r);
    fr.mode    = 2'(m);
    fr.keys    = KEYS_W'(k);
    fr.mouse   = MOUSE_W'(d);
    return fr;
  endfunction

  function automatic logic [STICK_W-1:0] random_stick();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return STICK_W'(STICK_CENTRE - 20 + $urandom_range(0, 40));
      default: return STICK_W'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t fr;
    fr.strafe  = random_stick();
    fr.forward = random_stick();
    fr.rotate  = random_stick();
    fr.mode    = 2'($urandom_range(0, 3));
    fr.keys    = ($urandom_range(0, 1) == 0) ? KEYS_W'($urandom_range(0, 63))
                                              : KEYS_W'($urandom);
    case ($urandom_range(0, 7))
      0:       fr.mouse = '0;
      1:       fr.mouse = 16'sh7FFF;
      2:       fr.mouse = 16'sh8000;
      3, 4:    fr.mouse = MOUSE_W'($urandom);
      default: fr.mouse = MOUSE_W'(int'($urandom_range(0, 80)) - 40);
    endcase
    return fr;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_frame(frame_t fr);
    in_valid         <= 1'b1;
    in_stick_strafe  <= fr.strafe;
    in_stick_forward <= fr.forward;
    in_stick_rotate  <= fr.rotate;
    in_mode_switch   <= fr.mode;
    in_key_mask      <= fr.keys;
    in_mouse_dx      <= fr.mouse;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_idle(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_MARGIN) @(posedge clk);
  endtask

  // Write one register; caller lowers the enable after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SCALE_W'(val);
    @(posedge clk);
    sb.write_scale(idx, SCALE_W'(val));
  endtask

  task automatic set_scales(int unsigned hi, int unsigned nm, int unsigned lo);
    write_reg(CFG_HIGH, hi);
    write_reg(CFG_NORMAL, nm);
    write_reg(CFG_LOW, lo);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Bursts of random frames with random gaps
  task automatic random_traffic(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_frame(random_frame());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 8));
    end
  endtask

  initial begin
    int kw, ks, ka, kd, kshift, kctrl;
    kw = 1 << KEY_W;
    ks = 1 << KEY_S;
    ka = 1 << KEY_A;
    kd = 1 << KEY_D;
    kshift = 1 << KEY_BOOST;
    kctrl  = 1 << KEY_CRAWL;
    sb = new();
    cycle_count   = 0;
    settings_used = 1;
    hold_off_req  = 1'b0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_stick_strafe  <= '0;
    in_stick_forward <= '0;
    in_stick_rotate  <= '0;
    in_mode_switch   <= '0;
    in_key_mask      <= '0;
    in_mouse_dx      <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset scales
    send_frame(make_frame(1024, 1024, 1024, 0, 0, 0));          // no demand at all
    send_frame(make_frame(0, 0, 0, 1, 0, 0));
    send_frame(make_frame(2047, 2047, 2047, 2, 0, 0));
    send_frame(make_frame(1024, 1024, 1024, 0, kw, 0));
    send_frame(make_frame(1024, 1024, 1024, 3, ks | ka, 0));
    send_frame(make_frame(1500, 700, 1024, 2, kd | kshift | kctrl, 0)); // Shift beats Ctrl
    send_frame(make_frame(900, 1300, 1100, 1, kctrl, 0));
    send_frame(make_frame(1024, 1024, 2047, 3, 0, 32767));
    send_frame(make_frame(0, 2047, 0, 0, 0, -32768));
    send_frame(make_frame(1024, 1024, 1024, 1, 16'hFFFF, 0));
    send_frame(make_frame(1024, 1024, 1024, 2, 16'hFFC0, 0));   // unused keys only
    send_frame(make_frame(1800, 1024, 1024, 3, 16'hFFC0, 0));
    send_frame(make_frame(2047, 0, 1024, 0, 0, 0));
    send_frame(make_frame(1400, 1024, 600, 1, 0, -5));
    send_frame(make_frame(1024, 1024, 1024, 0, kw | ks | ka | kd, 0)); // keys cancel
    send_frame(make_frame(1024, 1024, 1054, 2, 0, -1));        // mouse cancels stick
    send_frame(make_frame(1023, 1025, 1024, 0, 0, 0));
    send_frame(make_frame(0, 0, 0, 3, ks | ka | kctrl, -32768));
    send_frame(make_frame(2047, 2047, 2047, 1, kw | kd | kshift, 32767));
    random_traffic(PHASE_ITEMS);
    drain();

    // Largest scales, then a long output stall while requests keep coming
    set_scales(1023, 1023, 1023);
    random_traffic(PHASE_ITEMS / 2);
    hold_off_req = 1'b1;
    for (int i = 0; i < 100; i++) send_frame(random_frame());
    random_traffic(PHASE_ITEMS / 2);
    drain();

    // Zero scales: every wheel speed collapses to zero
    set_scales(0, 0, 0);
    random_traffic(PHASE_ITEMS / 2);
    drain();

    // Distinct scales per register, plus a write to the unused index
    write_reg(CFG_SPARE, 999);
    set_scales(1023, 1, 517);
    random_traffic(PHASE_ITEMS);
    drain();

    // Random scales; pause mid-phase until all results are back
    set_scales($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    random_traffic(PHASE_ITEMS / 2);
    drain();
    random_traffic(PHASE_ITEMS / 2);
    drain();

    set_scales($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    random_traffic(PHASE_ITEMS);
    drain();

    $display("Run covered %0d frames under %0d scale settings, %0d results checked.",
             sb.frames_seen, settings_used, sb.results_checked);
    $display("Included: key and stick extremes, mouse limits, long output stall, full drains.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
